// ===== rtl/core/fjrs_pkg.sv =====
// ----------------------------------------------------------------------------
// fjrs_pkg
// Types and constants shared by the filtered jet rank sorter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fjrs_pkg;

   localparam int JET_INDEX_WIDTH = 6;
   localparam int ARRIVAL_WIDTH   = 7;
   localparam logic [ARRIVAL_WIDTH-1:0] ARRIVAL_LIMIT = 7'd64;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_PT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ETA    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REQUIRE_ID = 2'd2;

   localparam logic [15:0] MIN_PT_RESET     = 16'd0;
   localparam logic [10:0] MAX_ETA_RESET    = 11'd2047;
   localparam logic        REQUIRE_ID_RESET = 1'b0;

   typedef struct packed {
      logic [15:0]        pt;
      logic signed [11:0] eta;
      logic signed [15:0] btag;
      logic               id_pass;
      logic               last_jet;
   } req_word_type;

   typedef struct packed {
      logic [JET_INDEX_WIDTH-1:0] jet_index;
      logic                       last_result;
      logic                       empty_res;
      logic                       overflow;
   } rsp_word_type;

   // classified jet, front to back
   typedef struct packed {
      logic                       keep;
      logic [JET_INDEX_WIDTH-1:0] jet_index;
      logic signed [15:0]         score;
      logic                       late_ovf;
      logic                       last;
   } jet_word_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/fjrs_front.sv =====
// ----------------------------------------------------------------------------
// fjrs_front
// Config registers, jet cuts and arrival numbering; pushes classified words.
// ----------------------------------------------------------------------------
`default_nettype none

module fjrs_front import fjrs_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_word_type               req_word,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire logic                       queue_full,
   output logic                            push,
   output jet_word_type                    push_word
);

   logic [15:0]              min_pt_ff, min_pt_in;
   logic [10:0]              max_eta_ff, max_eta_in;
   logic                     require_id_ff, require_id_in;
   logic [ARRIVAL_WIDTH-1:0] arrival_ff, arrival_in;

   logic        at_limit;
   logic        pass;
   logic [11:0] abs_eta;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign push      = req_valid && !req_stall;

   always_comb begin
      // -2048 negates to 0x800, which exceeds any max_eta
      abs_eta  = req_word.eta[11] ? (12'd0 - req_word.eta) : req_word.eta;
      at_limit = (arrival_ff >= ARRIVAL_LIMIT);
      pass     = (req_word.pt >= min_pt_ff) &&
                 (abs_eta <= {1'b0, max_eta_ff}) &&
                 !(require_id_ff && !req_word.id_pass);

      push_word.keep      = pass && !at_limit;
      push_word.jet_index = arrival_ff[JET_INDEX_WIDTH-1:0];
      push_word.score     = req_word.btag;
      push_word.late_ovf  = at_limit;
      push_word.last      = req_word.last_jet;

      arrival_in = arrival_ff;
      if (push) begin
         if (req_word.last_jet) begin
            arrival_in = '0;
         end else if (!at_limit) begin
            arrival_in = arrival_ff + ARRIVAL_WIDTH'(1);
         end
      end

      min_pt_in     = min_pt_ff;
      max_eta_in    = max_eta_ff;
      require_id_in = require_id_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_PT:     min_pt_in     = csr_data[15:0];
            CSR_MAX_ETA:    max_eta_in    = csr_data[10:0];
            CSR_REQUIRE_ID: require_id_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pt_ff     <= MIN_PT_RESET;
         max_eta_ff    <= MAX_ETA_RESET;
         require_id_ff <= REQUIRE_ID_RESET;
         arrival_ff    <= '0;
      end else begin
         min_pt_ff     <= min_pt_in;
         max_eta_ff    <= max_eta_in;
         require_id_ff <= require_id_in;
         arrival_ff    <= arrival_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fjrs_queue.sv =====
// ----------------------------------------------------------------------------
// fjrs_queue
// Two-word queue between the front end and the sorting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fjrs_queue import fjrs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire jet_word_type push_word,
   input  wire logic         pop,
   output queue_status_type  status,
   output jet_word_type      pop_word
);

   jet_word_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      status.valid = (count_ff != 2'd0);
      status.full  = (count_ff == 2'd2);
      do_push      = push && !status.full;
      do_pop       = pop && status.valid;
      pop_word     = mem[rd_ptr_ff];
      wr_ptr_in    = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fjrs_back.sv =====
// ----------------------------------------------------------------------------
// fjrs_back
// Compare-and-shift insertion rank array; drains the ranking on the last jet.
// ----------------------------------------------------------------------------
`default_nettype none

module fjrs_back import fjrs_pkg::*; #(
   parameter int MAX_JETS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire jet_word_type     q_word,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_word_type          rsp_word
);

   localparam int KW = $clog2(MAX_JETS + 1);

   typedef enum logic {ST_RUN, ST_DRAIN} state_type;

   state_type    state_ff, state_in;
   logic [KW-1:0] kept_ff, kept_in;
   logic         ovf_ff, ovf_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic [JET_INDEX_WIDTH-1:0] rank_index_ff [MAX_JETS];
   logic signed [15:0]         rank_score_ff [MAX_JETS];

   logic [MAX_JETS-1:0] ins, ins_prev;
   logic full, out_free, do_insert, do_shift;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      // ins[k]: the new jet lands at or above cell k (monotone over k)
      for (int k = 0; k < MAX_JETS; k++) begin
         ins[k] = (KW'(k) >= kept_ff) || (q_word.score > rank_score_ff[k]);
      end
      ins_prev = ins << 1;
      full     = (kept_ff == KW'(MAX_JETS));
      out_free = !rsp_valid_ff || !rsp_stall;
      q_pop    = (state_ff == ST_RUN) && q_status.valid;
      do_insert = q_pop && q_word.keep;
      do_shift  = (state_ff == ST_DRAIN) && out_free;

      state_in     = state_ff;
      kept_in      = kept_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      case (state_ff)
         ST_RUN: begin
            if (q_pop) begin
               if (do_insert && !full) begin
                  kept_in = kept_ff + KW'(1);
               end
               ovf_in = ovf_ff || q_word.late_ovf || (do_insert && full);
               if (q_word.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.overflow = ovf_ff;
               if (kept_ff == '0) begin
                  rsp_word_in.jet_index   = '0;
                  rsp_word_in.empty_res   = 1'b1;
                  rsp_word_in.last_result = 1'b1;
               end else begin
                  rsp_word_in.jet_index   = rank_index_ff[0];
                  rsp_word_in.empty_res   = 1'b0;
                  rsp_word_in.last_result = (kept_ff == KW'(1));
               end
               if (kept_ff <= KW'(1)) begin
                  state_in = ST_RUN;
                  kept_in  = '0;
                  ovf_in   = 1'b0;
               end else begin
                  kept_in = kept_ff - KW'(1);
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         kept_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   // rank cells: insert shifts down, drain shifts up toward cell 0
   for (genvar k = 0; k < MAX_JETS; k++) begin : g_cell
      logic [JET_INDEX_WIDTH-1:0] up_index, down_index;
      logic signed [15:0]         up_score, down_score;

      if (k == 0) begin : g_top
         assign up_index = q_word.jet_index;
         assign up_score = q_word.score;
      end else begin : g_mid
         assign up_index = rank_index_ff[k-1];
         assign up_score = rank_score_ff[k-1];
      end

      if (k == MAX_JETS - 1) begin : g_bottom
         assign down_index = rank_index_ff[k];
         assign down_score = rank_score_ff[k];
      end else begin : g_below
         assign down_index = rank_index_ff[k+1];
         assign down_score = rank_score_ff[k+1];
      end

      always_ff @(posedge clock) begin
         if (do_insert && ins[k]) begin
            if (!ins_prev[k]) begin
               rank_index_ff[k] <= q_word.jet_index;
               rank_score_ff[k] <= q_word.score;
            end else begin
               rank_index_ff[k] <= up_index;
               rank_score_ff[k] <= up_score;
            end
         end else if (do_shift) begin
            rank_index_ff[k] <= down_index;
            rank_score_ff[k] <= down_score;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/filtered_jet_rank_sorter_core.sv =====
// ----------------------------------------------------------------------------
// filtered_jet_rank_sorter_core
// Filters the jets of an event and returns surviving positions by tag score.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  one jet word per accepted cycle (req_valid high, req_stall low).
//          The word with last_jet set closes the event.
//   rsp_*  ranked positions, highest score first; last_result marks the end,
//          empty_res a single result for an event with no surviving jet.
//   csr_*  register writes (min_pt, max_eta, require_id); always ready.
// Throughput: one jet per cycle while an event is collected; the two-word
//   queue between the cut stage and the rank array absorbs a short stall.
// After the last jet is taken it is written into the queue; the rank array pops
//   it, enters its drain state and then registers the first result. Draining
//   gives max(kept, 1) results, one result per cycle unless rsp_stall holds the
//   output; the rank array takes no jet meanwhile, and req_stall rises once the queue fills.
// A stalled rsp word holds; a new result is loaded as the old one is taken.
// Reset clears the registers to their defaults and empties queue and array.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_jet_rank_sorter_core import fjrs_pkg::*; #(
   parameter int MAX_JETS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_word_type               req_word,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_word_type                    rsp_word,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic             push, pop;
   jet_word_type     push_word, pop_word;
   queue_status_type q_status;

   fjrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (q_status.full),
      .push       (push),
      .push_word  (push_word)
   );

   fjrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .status    (q_status),
      .pop_word  (pop_word)
   );

   fjrs_back #(.MAX_JETS(MAX_JETS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_word    (pop_word),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.empty_res |-> rsp_word.last_result && rsp_word.jet_index == '0)
      else $error("empty result not marked last");

   a_full_has_data: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.valid && req_stall)
      else $error("queue full flag inconsistent");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
